### sv/afd_pkg.sv
// afd_pkg: types and constants shared by the API frame deframer files.
// No dependencies; compiled first.
`timescale 1ns / 1ps

package afd_pkg;

	// byte codes of the framing
	localparam logic [7:0] START_BYTE = 8'h7E;
	localparam logic [7:0] ESC_BYTE   = 8'h7D;
	localparam logic [7:0] ESC_XOR    = 8'h20;
	localparam logic [7:0] SUM_BASE   = 8'hFF;

	localparam int BYTE_W = 8;
	localparam int LEN_W  = 16;

	// reset value of the escaped mode register
	localparam logic ESC_MODE_RST = 1'b1;

	// parser phase
	typedef enum logic [2:0] {
		PH_HUNT,
		PH_LEN_HI,
		PH_LEN_LO,
		PH_DATA,
		PH_CHECK
	} phase_t;

	// result payload
	typedef struct packed {
		logic [BYTE_W-1:0] out_byte;
		logic              is_frame_type;
		logic              frame_end;
		logic              checksum_ok;
	} result_t;

endpackage

### sv/afd_if.sv
// afd_if: valid/ready channel interfaces for the deframer input and result items.
// Depends on afd_pkg.
`timescale 1ns / 1ps

interface afd_rx_if;
	import afd_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] rx_byte;

	modport source (output valid, output rx_byte, input ready);
	modport sink   (input valid, input rx_byte, output ready);
	modport mon    (input valid, input rx_byte, input ready);
endinterface

interface afd_res_if;
	import afd_pkg::*;

	logic              valid;
	logic              ready;
	logic [BYTE_W-1:0] out_byte;
	logic              is_frame_type;
	logic              frame_end;
	logic              checksum_ok;

	modport source (output valid, output out_byte, output is_frame_type,
		output frame_end, output checksum_ok, input ready);
	modport sink   (input valid, input out_byte, input is_frame_type,
		input frame_end, input checksum_ok, output ready);
	modport mon    (input valid, input out_byte, input is_frame_type,
		input frame_end, input checksum_ok, input ready);
endinterface

### sv/api_frame_deframer_unit.sv
// api_frame_deframer_unit: byte-serial API frame receiver with optional escaping.
// Depends on afd_pkg and the channel interfaces in afd_if.sv.
//
//   channel | dir | handshake     | payload
//   rx      | in  | valid / ready | rx_byte[7:0]
//   res     | out | valid / ready | out_byte[7:0], is_frame_type, frame_end, checksum_ok
//   cfg     | in  | cfg_we        | cfg_wdata (escaped mode)
//
// One item per cycle sustained: an input register feeds the byte parser, whose
// result is registered in an output register once the parser processes the item.
// The parser stalls only when it holds a result and the output register is still full.
// Reset clears the parse state, both valid flags, and sets escaped mode.
// rx.ready stays high while the output drains or the held item makes no result.
`timescale 1ns / 1ps

module api_frame_deframer_unit (
	input  logic      clk,
	input  logic      arst_n,
	afd_rx_if.sink    rx,
	afd_res_if.source res,
	input  logic      cfg_we,
	input  logic      cfg_wdata
);
	import afd_pkg::*;

	// input register
	logic              valid_s1;
	logic [BYTE_W-1:0] byte_s1;

	// parse state
	logic              esc_mode_q;
	phase_t            phase_q, phase_d;
	logic [LEN_W-1:0]  left_q, left_d;
	logic [BYTE_W-1:0] sum_q, sum_d;
	logic              esc_pend_q, esc_pend_d;
	logic              first_q, first_d;
	logic [BYTE_W-1:0] len_hi_q, len_hi_d;

	// shared decode
	logic              start_hit;
	logic              esc_hit;
	logic              take;
	logic [BYTE_W-1:0] ubyte;

	// result side
	logic              emit;
	result_t           res_d;
	logic              res_valid_q;
	result_t           res_q;

	logic              out_free;
	logic              proc;

	// handshake
	assign out_free = !res_valid_q || res.ready;
	assign proc     = valid_s1 && (!emit || out_free);
	assign rx.ready = !valid_s1 || proc;

	// byte decode: restart, escape swallow and unescape
	always_comb begin
		start_hit = (phase_q == PH_HUNT || esc_mode_q) && byte_s1 == START_BYTE;
		esc_hit   = !esc_pend_q && esc_mode_q && byte_s1 == ESC_BYTE;
		take      = phase_q != PH_HUNT && !start_hit && !esc_hit;
		ubyte     = esc_pend_q ? (byte_s1 ^ ESC_XOR) : byte_s1;
	end

	// next parse state
	always_comb begin
		phase_d    = phase_q;
		left_d     = left_q;
		sum_d      = sum_q;
		esc_pend_d = esc_pend_q;
		first_d    = first_q;
		len_hi_d   = len_hi_q;
		if (start_hit) begin
			phase_d    = PH_LEN_HI;
			left_d     = '0;
			sum_d      = '0;
			esc_pend_d = 1'b0;
			first_d    = 1'b0;
			len_hi_d   = '0;
		end else if (esc_hit) begin
			esc_pend_d = 1'b1;
		end else if (take) begin
			esc_pend_d = 1'b0;
			unique case (phase_q)
				PH_LEN_HI: begin
					len_hi_d = ubyte;
					phase_d  = PH_LEN_LO;
				end
				PH_LEN_LO: begin
					left_d  = {len_hi_q, ubyte};
					sum_d   = '0;
					first_d = 1'b1;
					phase_d = ({len_hi_q, ubyte} != '0) ? PH_DATA : PH_CHECK;
				end
				PH_DATA: begin
					first_d = 1'b0;
					sum_d   = sum_q + ubyte;
					left_d  = left_q - LEN_W'(1);
					if (left_q == LEN_W'(1)) begin
						phase_d = PH_CHECK;
					end
				end
				PH_CHECK: begin
					phase_d  = PH_HUNT;
					left_d   = '0;
					sum_d    = '0;
					first_d  = 1'b0;
				end
				default: begin
					phase_d = PH_HUNT;
				end
			endcase
		end
	end

	// result for the held item
	always_comb begin
		emit  = take && (phase_q == PH_DATA || phase_q == PH_CHECK);
		res_d = '{
			out_byte:      ubyte,
			is_frame_type: phase_q == PH_DATA && first_q,
			frame_end:     phase_q == PH_CHECK,
			checksum_ok:   phase_q == PH_CHECK && (SUM_BASE - sum_q) == ubyte
		};
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			esc_mode_q <= ESC_MODE_RST;
		end else if (cfg_we) begin
			esc_mode_q <= cfg_wdata;
		end
	end

	// input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (rx.ready) begin
			valid_s1 <= rx.valid;
		end
	end

	always_ff @(posedge clk) begin
		if (rx.ready && rx.valid) begin
			byte_s1 <= rx.rx_byte;
		end
	end

	// parse state registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q    <= PH_HUNT;
			left_q     <= '0;
			sum_q      <= '0;
			esc_pend_q <= 1'b0;
			first_q    <= 1'b0;
			len_hi_q   <= '0;
		end else if (proc) begin
			phase_q    <= phase_d;
			left_q     <= left_d;
			sum_q      <= sum_d;
			esc_pend_q <= esc_pend_d;
			first_q    <= first_d;
			len_hi_q   <= len_hi_d;
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (proc && emit) begin
			res_valid_q <= 1'b1;
		end else if (res.ready) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (proc && emit) begin
			res_q <= res_d;
		end
	end

	assign res.valid         = res_valid_q;
	assign res.out_byte      = res_q.out_byte;
	assign res.is_frame_type = res_q.is_frame_type;
	assign res.frame_end     = res_q.frame_end;
	assign res.checksum_ok   = res_q.checksum_ok;

endmodule

### sv/afd_checker.sv
// afd_checker: port-level assertions for api_frame_deframer_unit, bound to it below.
// Depends on afd_pkg for the byte width.
`timescale 1ns / 1ps

module afd_checker (
	input logic                      clk,
	input logic                      arst_n,
	input logic                      rx_valid,
	input logic                      rx_ready,
	input logic                      res_valid,
	input logic                      res_ready,
	input logic [afd_pkg::BYTE_W-1:0] out_byte,
	input logic                      is_frame_type,
	input logic                      frame_end,
	input logic                      checksum_ok
);

	// a result is never both the frame type and the frame end
	a_type_not_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid |-> !(is_frame_type && frame_end))
		else $error("frame type item marked as frame end");

	// checksum flag only on the frame end item
	a_ok_with_end: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && checksum_ok) |-> frame_end)
		else $error("checksum_ok outside frame end");

	// with the output register empty the input side always takes an item
	a_rx_open: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid |-> rx_ready)
		else $error("input blocked with empty output");

	// stalled result holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(res_valid && !res_ready) |=>
			(res_valid && $stable({out_byte, is_frame_type, frame_end, checksum_ok})))
		else $error("stalled result changed");

endmodule

bind api_frame_deframer_unit afd_checker u_afd_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.rx_valid      (rx.valid),
	.rx_ready      (rx.ready),
	.res_valid     (res.valid),
	.res_ready     (res.ready),
	.out_byte      (res.out_byte),
	.is_frame_type (res.is_frame_type),
	.frame_end     (res.frame_end),
	.checksum_ok   (res.checksum_ok)
);
